@@ src/triangle_transform_and_slope_classify_defines.svh @@
// Assertion macros shared by the RTL
`ifndef TRIANGLE_TRANSFORM_AND_SLOPE_CLASSIFY_DEFINES_SVH
`define TRIANGLE_TRANSFORM_AND_SLOPE_CLASSIFY_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTSC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define TTSC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define TTSC_ASSERT_IMP(lbl, ante, cons)
`define TTSC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ src/ttsc_pkg.sv @@
`default_nettype none
package ttsc_pkg;

  // configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_ROW_X  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ROW_Y  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ROW_Z  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_TRANS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd4;

  // normal scaling and result formats
  localparam int ScaleW  = 30;           // scaled magnitudes stay below 2^30
  localparam int SqrtW   = 31;           // floor sqrt of a sum below 2^62
  localparam int SumW    = 62;
  localparam int QuoW    = 17;           // Q1.16 magnitude, 0..65536
  localparam int NrmW    = 18;
  localparam int ThrW    = 17;
  localparam logic [QuoW-1:0] QuoOne = 17'h10000;

  // pipeline depths
  localparam int XfLat   = 2;
  localparam int NormLat = 7 + SqrtW;
  localparam int DivLat  = 1 + QuoW;

  // request from the normal unit to one division lane
  typedef struct packed {
    logic [ScaleW-1:0] mag;
    logic [SqrtW-1:0]  len;
  } div_req_t;

endpackage
`default_nettype wire

@@ src/triangle_transform_and_slope_classify.sv @@
// Throughput: one triangle per cycle; the whole pipeline advances together
// and holds only while a finished result is stalled at the output register.
// Depth is set by the 31-stage square root and the 18-stage divider lanes.
// Reset (rst_ni low, asynchronous): all valids clear, config registers take defaults.
`default_nettype none
`include "triangle_transform_and_slope_classify_defines.svh"
module triangle_transform_and_slope_classify #(
  parameter int COORD_BITS = 21,
  parameter int COEF_BITS  = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [3*COORD_BITS-1:0]       vertex_a_local_i,
  input  wire logic [3*COORD_BITS-1:0]       vertex_b_local_i,
  input  wire logic [3*COORD_BITS-1:0]       vertex_c_local_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [3*COORD_BITS-1:0]            vertex_a_world_o,
  output logic [3*COORD_BITS-1:0]            vertex_b_world_o,
  output logic [3*COORD_BITS-1:0]            vertex_c_world_o,
  output logic signed [ttsc_pkg::NrmW-1:0]   normal_x_o,
  output logic signed [ttsc_pkg::NrmW-1:0]   normal_y_o,
  output logic signed [ttsc_pkg::NrmW-1:0]   normal_z_o,
  output logic                               surface_kind_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [ttsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [((3*COEF_BITS > 3*COORD_BITS) ? 3*COEF_BITS : 3*COORD_BITS)-1:0]
                                             cfg_data_i
);
  localparam int VW     = 3 * COORD_BITS;
  localparam int RW     = 3 * COEF_BITS;
  localparam int QW     = ttsc_pkg::QuoW;
  localparam int NW     = ttsc_pkg::NrmW;
  localparam int WDly   = ttsc_pkg::NormLat + ttsc_pkg::DivLat;
  localparam int NDly   = ttsc_pkg::DivLat;
  localparam int Stages = ttsc_pkg::XfLat + WDly + 1;
  localparam logic [COEF_BITS-1:0] CoefOne = COEF_BITS'(32'd65536);

  logic [2:0][RW-1:0]        rows_q;
  logic [VW-1:0]             trans_q;
  logic [ttsc_pkg::ThrW-1:0] thr_q;
  logic [Stages-1:0]         vld_q;
  logic                      en;
  logic [2:0][VW-1:0]        vin;
  logic [2:0][VW-1:0]        world;
  logic [2:0][VW-1:0]        wd_q [WDly];
  ttsc_pkg::div_req_t        req [3];
  logic [2:0]                neg;
  logic [2:0]                nd_q [NDly];
  logic [QW-1:0]             quo [3];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= RW'(CoefOne);
      rows_q[1] <= RW'(CoefOne) << COEF_BITS;
      rows_q[2] <= RW'(CoefOne) << (2 * COEF_BITS);
      trans_q   <= '0;
      thr_q     <= ttsc_pkg::ThrW'(32'd32768);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ttsc_pkg::REG_ROW_X:  rows_q[0] <= cfg_data_i[RW-1:0];
        ttsc_pkg::REG_ROW_Y:  rows_q[1] <= cfg_data_i[RW-1:0];
        ttsc_pkg::REG_ROW_Z:  rows_q[2] <= cfg_data_i[RW-1:0];
        ttsc_pkg::REG_TRANS:  trans_q   <= cfg_data_i[VW-1:0];
        ttsc_pkg::REG_THRESH: thr_q     <= cfg_data_i[ttsc_pkg::ThrW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advance and valid line
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;
  assign out_valid_o = vld_q[Stages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Stages-2:0], in_valid_i};
    end
  end

  // vertex lanes
  assign vin = {vertex_c_local_i, vertex_b_local_i, vertex_a_local_i};

  for (genvar v = 0; v < 3; v++) begin : g_lane
    ttsc_xform_lane #(
      .COORD_BITS(COORD_BITS),
      .COEF_BITS (COEF_BITS)
    ) u_xform (
      .clk_i  (clk_i),
      .en_i   (en),
      .vert_i (vin[v]),
      .rows_i (rows_q),
      .trans_i(trans_q),
      .world_o(world[v])
    );
  end

  // face normal: cross product, scaling and length
  ttsc_normal #(
    .COORD_BITS(COORD_BITS)
  ) u_normal (
    .clk_i  (clk_i),
    .en_i   (en),
    .world_i(world),
    .req_o  (req),
    .neg_o  (neg)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    ttsc_div_lane u_div (
      .clk_i(clk_i),
      .en_i (en),
      .req_i(req[k]),
      .quo_o(quo[k])
    );
  end

  // world vertices and signs ride alongside the normal
  always_ff @(posedge clk_i) begin
    if (en) begin
      wd_q[0] <= world;
      for (int i = 1; i < WDly; i++) begin
        wd_q[i] <= wd_q[i-1];
      end
      nd_q[0] <= neg;
      for (int i = 1; i < NDly; i++) begin
        nd_q[i] <= nd_q[i-1];
      end
    end
  end

  // merge: clamp, sign and classify into the output register
  always_ff @(posedge clk_i) begin
    logic [QW-1:0] qc [3];
    logic signed [NW-1:0] n [3];
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        qc[k] = (quo[k] > ttsc_pkg::QuoOne) ? ttsc_pkg::QuoOne : quo[k];
        n[k]  = nd_q[NDly-1][k] ? -NW'(qc[k]) : NW'(qc[k]);
      end
      vertex_a_world_o <= wd_q[WDly-1][0];
      vertex_b_world_o <= wd_q[WDly-1][1];
      vertex_c_world_o <= wd_q[WDly-1][2];
      normal_x_o       <= n[0];
      normal_y_o       <= n[1];
      normal_z_o       <= n[2];
      surface_kind_o   <= !(ttsc_pkg::ThrW'(qc[1]) >= thr_q);
    end
  end

  // checks
  `TTSC_ASSERT_IMP(a_stall_only_when_full, in_stall_o, out_valid_o)
  `TTSC_ASSERT_IMP(a_normal_y_range, out_valid_o, (normal_y_o <= 18'sd65536) && (normal_y_o >= -18'sd65536))
  `TTSC_ASSERT_IMP(a_zero_normal_is_wall, out_valid_o && normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0 && !surface_kind_o, thr_q == '0)
  `TTSC_ASSERT_NXT(a_stalled_result_kept, out_valid_o && out_stall_i, out_valid_o)
endmodule
`default_nettype wire

@@ src/ttsc_xform_lane.sv @@
`default_nettype none
module ttsc_xform_lane #(
  parameter int COORD_BITS = 21,
  parameter int COEF_BITS  = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               en_i,
  input  wire logic [3*COORD_BITS-1:0]            vert_i,
  input  wire logic [2:0][3*COEF_BITS-1:0]        rows_i,
  input  wire logic [3*COORD_BITS-1:0]            trans_i,
  output logic      [3*COORD_BITS-1:0]            world_o
);
  localparam int LW = COORD_BITS + 1;
  localparam int PW = LW + COEF_BITS;
  localparam int AW = PW + 3;
  localparam logic signed [AW-1:0] Hi   = AW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] Lo   = AW'(-(64'sd1 <<< (COORD_BITS - 1)));
  localparam logic signed [AW-1:0] Half = AW'(64'sd32768);

  logic signed [LW-1:0]        loc [3];
  logic signed [COEF_BITS-1:0] m [3][3];
  logic signed [PW-1:0]        prod_d [3][3];
  logic signed [PW-1:0]        prod_q [3][3];
  logic [3*COORD_BITS-1:0]     world_d;

  // axis swap to (x, -z, y) and products
  always_comb begin
    loc[0] = {vert_i[COORD_BITS-1], vert_i[COORD_BITS-1:0]};
    loc[1] = -{vert_i[3*COORD_BITS-1], vert_i[3*COORD_BITS-1:2*COORD_BITS]};
    loc[2] = {vert_i[2*COORD_BITS-1], vert_i[2*COORD_BITS-1:COORD_BITS]};
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        m[i][j]      = rows_i[i][j*COEF_BITS +: COEF_BITS];
        prod_d[i][j] = loc[i] * m[i][j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  // sum, round half up from the Q.16 coefficient scale back to coordinate units, saturate
  always_comb begin
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] shr;
    logic signed [COORD_BITS-1:0] tr;
    world_d = '0;
    for (int j = 0; j < 3; j++) begin
      tr  = trans_i[j*COORD_BITS +: COORD_BITS];
      acc = (AW'(tr) <<< 16) + AW'(prod_q[0][j]) + AW'(prod_q[1][j])
          + AW'(prod_q[2][j]) + Half;
      shr = acc >>> 16;
      if (shr > Hi) begin
        world_d[j*COORD_BITS +: COORD_BITS] = Hi[COORD_BITS-1:0];
      end else if (shr < Lo) begin
        world_d[j*COORD_BITS +: COORD_BITS] = Lo[COORD_BITS-1:0];
      end else begin
        world_d[j*COORD_BITS +: COORD_BITS] = shr[COORD_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      world_o <= world_d;
    end
  end
endmodule
`default_nettype wire

@@ src/ttsc_normal.sv @@
`default_nettype none
module ttsc_normal #(
  parameter int COORD_BITS = 21
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [2:0][3*COORD_BITS-1:0]  world_i,
  output ttsc_pkg::div_req_t                 req_o [3],
  output logic [2:0]                         neg_o
);
  localparam int EW  = COORD_BITS + 1;
  localparam int PW  = 2 * EW;
  localparam int CW  = PW + 1;
  localparam int CBW = $clog2(CW);
  localparam int SW  = ttsc_pkg::ScaleW;
  localparam int NS  = ttsc_pkg::SqrtW;
  localparam int XW  = ttsc_pkg::SumW;

  logic signed [EW-1:0] e1_q [3];
  logic signed [EW-1:0] e2_q [3];
  logic signed [PW-1:0] p_q [6];
  logic [CW-1:0]        mag_q [3];
  logic [CW-1:0]        mag1_q [3];
  logic [CW-1:0]        mx_q;
  logic [SW-1:0]        smag_q [3];
  logic [SW-1:0]        smag2_q [3];
  logic [2*SW-1:0]      sq_q [3];
  logic [2:0]           neg_q [4];
  logic [2:0]           sneg_q [NS+1];
  logic [XW-1:0]        rx_q [NS+1];
  logic [XW-1:0]        rr_q [NS+1];
  logic [SW-1:0]        rm_q [NS+1][3];

  // edges from vertex 0
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        e1_q[k] <= EW'(signed'(world_i[1][k*COORD_BITS +: COORD_BITS]))
                 - EW'(signed'(world_i[0][k*COORD_BITS +: COORD_BITS]));
        e2_q[k] <= EW'(signed'(world_i[2][k*COORD_BITS +: COORD_BITS]))
                 - EW'(signed'(world_i[0][k*COORD_BITS +: COORD_BITS]));
      end
    end
  end

  // cross product terms
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= e1_q[1] * e2_q[2];
      p_q[1] <= e1_q[2] * e2_q[1];
      p_q[2] <= e1_q[2] * e2_q[0];
      p_q[3] <= e1_q[0] * e2_q[2];
      p_q[4] <= e1_q[0] * e2_q[1];
      p_q[5] <= e1_q[1] * e2_q[0];
    end
  end

  // difference, sign and magnitude
  always_ff @(posedge clk_i) begin
    logic signed [CW-1:0] c;
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        c = CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
        neg_q[0][k] <= c[CW-1];
        mag_q[k]    <= c[CW-1] ? CW'(-c) : CW'(c);
      end
    end
  end

  // largest magnitude
  always_ff @(posedge clk_i) begin
    logic [CW-1:0] m01;
    if (en_i) begin
      m01      = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
      mx_q     <= (m01 > mag_q[2]) ? m01 : mag_q[2];
      mag1_q   <= mag_q;
      neg_q[1] <= neg_q[0];
    end
  end

  // shift all magnitudes so the largest is below 2^30
  always_ff @(posedge clk_i) begin
    logic [CBW-1:0] hb;
    logic [CBW-1:0] sh;
    if (en_i) begin
      hb = '0;
      for (int b = 0; b < CW; b++) begin
        if (mx_q[b]) begin
          hb = CBW'(b);
        end
      end
      sh = (hb >= CBW'(SW)) ? hb - CBW'(SW - 1) : '0;
      for (int k = 0; k < 3; k++) begin
        smag_q[k] <= SW'(mag1_q[k] >> sh);
      end
      neg_q[2] <= neg_q[1];
    end
  end

  // squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= smag_q[k] * smag_q[k];
      end
      smag2_q  <= smag_q;
      neg_q[3] <= neg_q[2];
    end
  end

  // sum of squares feeds the root pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= XW'(sq_q[0]) + XW'(sq_q[1]) + XW'(sq_q[2]);
      rr_q[0]   <= '0;
      rm_q[0]   <= smag2_q;
      sneg_q[0] <= neg_q[3];
    end
  end

  // integer square root, one result bit per stage
  for (genvar t = 1; t <= NS; t++) begin : g_sqrt
    localparam int K = NS - t;
    localparam logic [XW:0] Bit = (XW+1)'(1) << (2 * K);
    always_ff @(posedge clk_i) begin
      logic [XW:0] trial;
      if (en_i) begin
        trial = {1'b0, rr_q[t-1]} + Bit;
        if ({1'b0, rx_q[t-1]} >= trial) begin
          rx_q[t] <= XW'({1'b0, rx_q[t-1]} - trial);
          rr_q[t] <= XW'((rr_q[t-1] >> 1) + Bit);
        end else begin
          rx_q[t] <= rx_q[t-1];
          rr_q[t] <= rr_q[t-1] >> 1;
        end
        rm_q[t]   <= rm_q[t-1];
        sneg_q[t] <= sneg_q[t-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      req_o[k].mag = rm_q[NS][k];
      req_o[k].len = rr_q[NS][NS-1:0];
    end
    neg_o = sneg_q[NS];
  end
endmodule
`default_nettype wire

@@ src/ttsc_div_lane.sv @@
`default_nettype none
module ttsc_div_lane (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  ttsc_pkg::div_req_t       req_i,
  output logic [ttsc_pkg::QuoW-1:0] quo_o
);
  localparam int QW = ttsc_pkg::QuoW;
  localparam int LW = ttsc_pkg::SqrtW;
  localparam int NW = ttsc_pkg::ScaleW + 17;

  logic [NW-1:0] r_q [QW+1];
  logic [LW-1:0] d_q [QW+1];
  logic [QW-1:0] q_q [QW+1];
  logic          z_q [QW+1];

  // numerator with half the divisor added for rounding
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0] <= NW'({req_i.mag, 16'b0}) + NW'(req_i.len >> 1);
      d_q[0] <= req_i.len;
      q_q[0] <= '0;
      z_q[0] <= (req_i.len == '0);
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar t = 1; t <= QW; t++) begin : g_div
    localparam int K = QW - t;
    always_ff @(posedge clk_i) begin
      logic [NW:0] den;
      if (en_i) begin
        den = (NW+1)'(d_q[t-1]) << K;
        if ({1'b0, r_q[t-1]} >= den) begin
          r_q[t]    <= NW'({1'b0, r_q[t-1]} - den);
          q_q[t]    <= q_q[t-1] | (QW'(1) << K);
        end else begin
          r_q[t]    <= r_q[t-1];
          q_q[t]    <= q_q[t-1];
        end
        d_q[t] <= d_q[t-1];
        z_q[t] <= z_q[t-1];
      end
    end
  end

  assign quo_o = z_q[QW] ? '0 : q_q[QW];
endmodule
`default_nettype wire
